// ===== src/bsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants for the byte stuffing framer with parity trailer.
// ----------------------------------------------------------------------------
package bsf_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] FLAG_RESET = 8'd36;
    localparam logic [7:0] ESC_RESET  = 8'd47;

    // configuration register indexes
    localparam logic CFG_FLAG = 1'b0;
    localparam logic CFG_ESC  = 1'b1;

    // emission phases of one payload byte
    localparam int unsigned PH_W   = 3;
    localparam logic [PH_W-1:0] PH_OPEN  = 3'd0;
    localparam logic [PH_W-1:0] PH_ESC   = 3'd1;
    localparam logic [PH_W-1:0] PH_DATA  = 3'd2;
    localparam logic [PH_W-1:0] PH_CLOSE = 3'd3;
    localparam logic [PH_W-1:0] PH_TRAIL = 3'd4;

    typedef struct packed {
        logic [7:0] flag_char;
        logic [7:0] escape_char;
    } t_cfg;

    // classified payload byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       needs_esc;
    } t_cmd;

endpackage
`default_nettype wire

// ===== src/bsf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsf_front
// Accepts payload bytes and marks those that must be escaped.
// ----------------------------------------------------------------------------
module bsf_front (
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_first_byte,
    input  wire logic          i_last_byte,
    input  wire bsf_pkg::t_cfg i_cfg,
    input  wire logic          i_q_full,
    output logic               o_q_wr,
    output bsf_pkg::t_cmd      o_q_cmd
);
    import bsf_pkg::*;

    assign full   = i_q_full;
    assign o_q_wr = push && !i_q_full;

    always_comb begin
        o_q_cmd.data_byte  = i_data_byte;
        o_q_cmd.first_byte = i_first_byte;
        o_q_cmd.last_byte  = i_last_byte;
        o_q_cmd.needs_esc  = (i_data_byte == i_cfg.flag_char) ||
                             (i_data_byte == i_cfg.escape_char);
    end

endmodule
`default_nettype wire

// ===== src/bsf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsf_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module bsf_queue #(
    parameter int unsigned DEPTH = bsf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire bsf_pkg::t_cmd i_wr_cmd,
    input  wire logic          i_rd,
    output bsf_pkg::t_cmd      o_rd_cmd,
    output logic               o_full,
    output logic               o_empty
);
    import bsf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_go, rd_go;

    assign o_full   = (r_count == CNT_FULL);
    assign o_empty  = (r_count == '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];
    assign wr_go    = i_wr && !o_full;
    assign rd_go    = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + 1'b1;
        end else if (rd_go && !wr_go) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/bsf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsf_back
// Sequences the frame bytes of each queued item, keeps the running parity
// and holds the oldest result in an output register.
// ----------------------------------------------------------------------------
module bsf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bsf_pkg::t_cfg i_cfg,
    input  wire bsf_pkg::t_cmd i_q_cmd,
    input  wire logic          i_q_empty,
    output logic               o_q_rd,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         o_out_byte,
    output logic               o_is_trailer,
    output logic               o_end_of_run
);
    import bsf_pkg::*;

    logic            r_busy;
    t_cmd            r_cur;
    logic [PH_W-1:0] r_phase;
    logic [7:0]      r_par;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_trailer;
    logic            r_out_eor;

    t_cmd            src;
    logic [PH_W-1:0] phase;
    logic [PH_W-1:0] next_phase;
    logic            done;
    logic [7:0]      emit_byte;
    logic [7:0]      n_par;
    logic            advance;
    logic            have_work;

    assign empty        = !r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_trailer = r_out_trailer;
    assign o_end_of_run = r_out_eor;

    assign advance   = !r_out_valid || pop;
    assign have_work = r_busy || !i_q_empty;
    // head of queue is taken in the same cycle as its first byte goes out
    assign o_q_rd    = advance && !r_busy && !i_q_empty;

    always_comb begin
        src = r_busy ? r_cur : i_q_cmd;
        if (r_busy) begin
            phase = r_phase;
        end else if (i_q_cmd.first_byte) begin
            phase = PH_OPEN;
        end else if (i_q_cmd.needs_esc) begin
            phase = PH_ESC;
        end else begin
            phase = PH_DATA;
        end

        next_phase = PH_DATA;
        done       = 1'b0;
        emit_byte  = src.data_byte;
        n_par      = r_par;
        case (phase)
            PH_OPEN: begin
                emit_byte  = i_cfg.flag_char;
                n_par      = i_cfg.flag_char;
                next_phase = src.needs_esc ? PH_ESC : PH_DATA;
            end
            PH_ESC: begin
                emit_byte  = i_cfg.escape_char;
                n_par      = r_par ^ i_cfg.escape_char;
                next_phase = PH_DATA;
            end
            PH_DATA: begin
                emit_byte  = src.data_byte;
                n_par      = r_par ^ src.data_byte;
                next_phase = PH_CLOSE;
                done       = !src.last_byte;
            end
            PH_CLOSE: begin
                emit_byte  = i_cfg.flag_char;
                n_par      = r_par ^ i_cfg.flag_char;
                next_phase = PH_TRAIL;
            end
            PH_TRAIL: begin
                emit_byte  = r_par;
                n_par      = r_par;
                done       = 1'b1;
            end
            default: begin
                done       = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_OPEN;
            r_par       <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= have_work;
            if (have_work) begin
                r_busy  <= !done;
                r_phase <= next_phase;
                r_par   <= n_par;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && have_work) begin
            r_cur         <= src;
            r_out_byte    <= emit_byte;
            r_out_trailer <= (phase == PH_TRAIL);
            r_out_eor     <= done;
        end
    end

endmodule
`default_nettype wire

// ===== src/byte_stuffing_framer_with_parity.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffing_framer_with_parity
// Byte stuffing frame encoder with an XOR parity trailer.
// ----------------------------------------------------------------------------
// Each accepted payload byte yields one to five frame bytes, sent one per
// clock unless the output stalls: an opening flag when the byte starts a
// frame, an escape byte when it equals the flag or escape character, the
// byte itself, and for the last byte a closing flag and the parity trailer.
// The back sequencer emits one byte per cycle while not stalled: one for a
// plain byte, two for an escaped one, up to five for an escaped one-byte
// frame. A queue of QUEUE_DEPTH items lets input arrive one per cycle until
// it fills while the sequencer works; an output register holds the oldest
// result until popped. Flag and escape characters are set through the write
// port while the block is idle: the user's duty, not enforced by the block.
// ----------------------------------------------------------------------------
module byte_stuffing_framer_with_parity #(
    parameter int unsigned QUEUE_DEPTH = bsf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_is_trailer,
    output logic            o_end_of_run,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);
    import bsf_pkg::*;

    t_cfg r_cfg;
    logic q_wr, q_rd, q_full, q_empty;
    t_cmd q_wr_cmd, q_rd_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_char   <= FLAG_RESET;
            r_cfg.escape_char <= ESC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLAG: r_cfg.flag_char   <= i_cfg_data;
                CFG_ESC:  r_cfg.escape_char <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bsf_front u_front (
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg        (r_cfg),
        .i_q_full     (q_full),
        .o_q_wr       (q_wr),
        .o_q_cmd      (q_wr_cmd)
    );

    bsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_cmd (q_wr_cmd),
        .i_rd     (q_rd),
        .o_rd_cmd (q_rd_cmd),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    bsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_cmd      (q_rd_cmd),
        .i_q_empty    (q_empty),
        .o_q_rd       (q_rd),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_is_trailer (o_is_trailer),
        .o_end_of_run (o_end_of_run)
    );

endmodule
`default_nettype wire
